[hw/rtl/dpfa_pkg.sv]
// Shared types and constants for the demand page frame allocator.
// Holds the item structs, the result kind codes and the controller states.
// No dependencies.
package dpfa_pkg;

  localparam int VP_DEPTH = 1024;
  localparam int VP_W     = $clog2(VP_DEPTH);
  localparam int PP_DEPTH = 256;
  localparam int PP_W     = $clog2(PP_DEPTH);
  localparam int PP_CW    = $clog2(PP_DEPTH + 1);
  localparam int EQ_DEPTH = 32;
  localparam int EQ_AW    = $clog2(EQ_DEPTH);
  localparam int EQ_CW    = $clog2(EQ_DEPTH + 1);
  localparam int MAXP_W   = 9;
  localparam int KIND_W   = 3;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_EVICT = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_EVICT_KEPT     = 3'd0,
    K_EVICT_RELEASED = 3'd1,
    K_MAP_REUSE      = 3'd2,
    K_MAP_NEW        = 3'd3,
    K_ALREADY        = 3'd4,
    K_EXHAUSTED      = 3'd5,
    K_QUEUED         = 3'd6,
    K_QUEUE_FULL     = 3'd7
  } kind_t;

  typedef struct packed {
    op_t             op;
    logic [VP_W-1:0] page_id;
  } in_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [VP_W-1:0] virtual_page;
    logic [PP_W-1:0] physical_page;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [PP_W-1:0] frame;
  } pt_entry_t;

  typedef struct packed {
    logic            en;
    logic [VP_W-1:0] addr;
    pt_entry_t       data;
  } pt_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MAP_RD,
    ST_MAP_EVAL
  } state_t;

endpackage

[hw/rtl/demand_page_frame_allocator.sv]
// Top level of the demand page frame allocator: controller, eviction queue,
// frame stacks and the page table instance.
// Depends on dpfa_pkg and dpfa_ptab.
//
//   channel  ports                      direction  handshake
//   input    start, busy, in_item       in         taken when start && !busy
//   result   out_strobe, out_item       out        one-cycle strobe per result
//   config   cfg_we, cfg_wdata          in         written when cfg_we
//
// An evict item's result appears in the next cycle.
// A map item keeps busy high while the queue drain reads one queue entry and one
// page table entry per cycle in a three stage pipeline, followed by a read
// state and an evaluate state. Its final result appears in the cycle after that.
// After reset busy stays high while the page table is cleared one entry per
// cycle; configuration writes are taken meanwhile.
// Results cannot be stalled, so the block never waits on the receiver.
module demand_page_frame_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  dpfa_pkg::in_item_t          in_item,
  output logic                        out_strobe,
  output dpfa_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [dpfa_pkg::MAXP_W-1:0] cfg_wdata
);
  import dpfa_pkg::*;

  state_t           state_r, state_nxt;
  logic [MAXP_W-1:0] max_r;
  logic [PP_CW-1:0] reuse_cnt_r, reuse_cnt_nxt;
  logic [PP_CW-1:0] rel_cnt_r, rel_cnt_nxt;
  logic [PP_CW-1:0] fiu_r, fiu_nxt;
  logic [EQ_CW-1:0] evict_cnt_r, evict_cnt_nxt;
  logic [EQ_CW-1:0] issue_idx_r, issue_idx_nxt;
  logic             b_vld_r, b_vld_nxt;
  logic             c_vld_r, c_vld_nxt;
  logic [VP_W-1:0]  c_vp_r, c_vp_nxt;
  logic             fwd_vld_r, fwd_vld_nxt;
  logic [VP_W-1:0]  fwd_vp_r, fwd_vp_nxt;
  logic [VP_W-1:0]  page_r, page_nxt;
  out_item_t        out_r, out_nxt;
  logic             strobe_r, strobe_nxt;

  // Memories.
  logic [VP_W-1:0]  eq_mem [EQ_DEPTH];
  logic [PP_W-1:0]  rs_mem [PP_DEPTH];
  logic [PP_W-1:0]  ls_mem [PP_DEPTH];
  logic [VP_W-1:0]  eq_rdata_r;
  logic [PP_W-1:0]  rs_rdata_r;
  logic [PP_W-1:0]  ls_rdata_r;
  logic             eq_we;
  logic             rs_we;
  logic             ls_we;
  logic [PP_W-1:0]  evict_frame;

  logic [PP_CW-1:0] rs_top;
  logic [PP_CW-1:0] ls_top;
  logic [PP_CW-1:0] limit;
  logic             accept;
  logic             issue_done;
  logic             c_hit;

  logic [VP_W-1:0]  pt_raddr;
  pt_entry_t        pt_rdata;
  pt_wr_t           pt_wr;
  logic             pt_ready;

  dpfa_ptab u_ptab (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (pt_raddr),
    .rd_data (pt_rdata),
    .wr      (pt_wr),
    .ready   (pt_ready)
  );

  assign busy       = (state_r != ST_IDLE) || !pt_ready;
  assign accept     = start && !busy;
  assign issue_done = (issue_idx_r == evict_cnt_r);
  assign rs_top     = reuse_cnt_r - PP_CW'(1);
  assign ls_top     = rel_cnt_r - PP_CW'(1);
  assign limit      = (PP_CW'(max_r) > PP_CW'(PP_DEPTH)) ? PP_CW'(PP_DEPTH)
                                                          : PP_CW'(max_r);
  // An entry invalidated by the previous evaluation was read before that
  // write landed, so the hit is masked by the forwarded page.
  assign c_hit      = c_vld_r && pt_rdata.valid &&
                      !(fwd_vld_r && (fwd_vp_r == c_vp_r));
  assign evict_frame = pt_rdata.frame;

  always_ff @(posedge clk) begin
    eq_rdata_r <= eq_mem[issue_idx_r[EQ_AW-1:0]];
    rs_rdata_r <= rs_mem[rs_top[PP_W-1:0]];
    ls_rdata_r <= ls_mem[ls_top[PP_W-1:0]];
    if (eq_we) begin
      eq_mem[evict_cnt_r[EQ_AW-1:0]] <= in_item.page_id;
    end
    if (rs_we) begin
      rs_mem[reuse_cnt_r[PP_W-1:0]] <= evict_frame;
    end
    if (ls_we) begin
      ls_mem[rel_cnt_r[PP_W-1:0]] <= evict_frame;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.op == OP_MAP)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue_done && !b_vld_r) begin
          state_nxt = ST_MAP_RD;
        end
      end
      ST_MAP_RD:   state_nxt = ST_MAP_EVAL;
      ST_MAP_EVAL: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    reuse_cnt_nxt = reuse_cnt_r;
    rel_cnt_nxt   = rel_cnt_r;
    fiu_nxt       = fiu_r;
    evict_cnt_nxt = evict_cnt_r;
    issue_idx_nxt = issue_idx_r;
    b_vld_nxt     = 1'b0;
    c_vld_nxt     = b_vld_r;
    c_vp_nxt      = eq_rdata_r;
    fwd_vld_nxt   = c_hit;
    fwd_vp_nxt    = c_vp_r;
    page_nxt      = page_r;
    out_nxt       = out_r;
    strobe_nxt    = 1'b0;
    eq_we         = 1'b0;
    rs_we         = 1'b0;
    ls_we         = 1'b0;
    pt_raddr      = eq_rdata_r;
    pt_wr         = '0;

    // Last drain stage: unmap the page and stack its frame if its stack has room.
    if (c_hit) begin
      pt_wr.en            = 1'b1;
      pt_wr.addr          = c_vp_r;
      pt_wr.data          = '0;
      strobe_nxt          = 1'b1;
      out_nxt.virtual_page  = c_vp_r;
      out_nxt.physical_page = evict_frame;
      out_nxt.last          = 1'b0;
      if ((reuse_cnt_r < PP_CW'(evict_cnt_r >> 1)) &&
          (reuse_cnt_r < PP_CW'(PP_DEPTH))) begin
        rs_we         = 1'b1;
        reuse_cnt_nxt = reuse_cnt_r + PP_CW'(1);
        out_nxt.kind  = K_EVICT_KEPT;
      end else begin
        if (rel_cnt_r < PP_CW'(PP_DEPTH)) begin
          ls_we       = 1'b1;
          rel_cnt_nxt = rel_cnt_r + PP_CW'(1);
        end
        out_nxt.kind = K_EVICT_RELEASED;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.op == OP_EVICT) begin
            strobe_nxt            = 1'b1;
            out_nxt.virtual_page  = in_item.page_id;
            out_nxt.physical_page = '0;
            out_nxt.last          = 1'b1;
            if (evict_cnt_r < EQ_CW'(EQ_DEPTH)) begin
              eq_we         = 1'b1;
              evict_cnt_nxt = evict_cnt_r + EQ_CW'(1);
              out_nxt.kind  = K_QUEUED;
            end else begin
              out_nxt.kind = K_QUEUE_FULL;
            end
          end else begin
            page_nxt      = in_item.page_id;
            issue_idx_nxt = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (!issue_done) begin
          b_vld_nxt     = 1'b1;
          issue_idx_nxt = issue_idx_r + EQ_CW'(1);
        end
      end
      ST_MAP_RD: begin
        pt_raddr = page_r;
      end
      ST_MAP_EVAL: begin
        strobe_nxt            = 1'b1;
        evict_cnt_nxt         = '0;
        out_nxt.virtual_page  = page_r;
        out_nxt.last          = 1'b1;
        pt_wr.addr            = page_r;
        pt_wr.data.valid      = 1'b1;
        if (pt_rdata.valid) begin
          out_nxt.kind          = K_ALREADY;
          out_nxt.physical_page = pt_rdata.frame;
        end else if (reuse_cnt_r != '0) begin
          reuse_cnt_nxt         = rs_top;
          out_nxt.kind          = K_MAP_REUSE;
          out_nxt.physical_page = rs_rdata_r;
          pt_wr.en              = 1'b1;
          pt_wr.data.frame      = rs_rdata_r;
        end else if (rel_cnt_r != '0) begin
          rel_cnt_nxt           = ls_top;
          out_nxt.kind          = K_MAP_NEW;
          out_nxt.physical_page = ls_rdata_r;
          pt_wr.en              = 1'b1;
          pt_wr.data.frame      = ls_rdata_r;
        end else if (fiu_r < limit) begin
          fiu_nxt               = fiu_r + PP_CW'(1);
          out_nxt.kind          = K_MAP_NEW;
          out_nxt.physical_page = fiu_r[PP_W-1:0];
          pt_wr.en              = 1'b1;
          pt_wr.data.frame      = fiu_r[PP_W-1:0];
        end else begin
          out_nxt.kind          = K_EXHAUSTED;
          out_nxt.physical_page = '0;
        end
      end
      default: begin
        pt_raddr = eq_rdata_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_r       <= MAXP_W'(PP_DEPTH);
      reuse_cnt_r <= '0;
      rel_cnt_r   <= '0;
      fiu_r       <= '0;
      evict_cnt_r <= '0;
      issue_idx_r <= '0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      fwd_vld_r   <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      reuse_cnt_r <= reuse_cnt_nxt;
      rel_cnt_r   <= rel_cnt_nxt;
      fiu_r       <= fiu_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      issue_idx_r <= issue_idx_nxt;
      b_vld_r     <= b_vld_nxt;
      c_vld_r     <= c_vld_nxt;
      fwd_vld_r   <= fwd_vld_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_vp_r   <= c_vp_nxt;
    fwd_vp_r <= fwd_vp_nxt;
    page_r   <= page_nxt;
    out_r    <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  a_drain_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> (state_r == ST_DRAIN || state_r == ST_MAP_RD))
    else $error("drain result outside the drain");

  a_map_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAP_EVAL) |=> (out_strobe && out_item.last))
    else $error("map item ended without its final result");

  a_evict_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op == OP_EVICT) |=> (out_strobe && out_item.last))
    else $error("evict item gave no result");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (reuse_cnt_r <= PP_CW'(PP_DEPTH)) && (rel_cnt_r <= PP_CW'(PP_DEPTH)) &&
    (evict_cnt_r <= EQ_CW'(EQ_DEPTH)))
    else $error("stack or queue count out of range");

  a_no_pipe_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!b_vld_r && !c_vld_r))
    else $error("drain pipeline busy while idle");

endmodule

[hw/rtl/dpfa_ptab.sv]
// Page table memory: one entry per virtual page, valid bit and frame.
// Runs a clearing pass after reset and reports ready when it is done.
// Depends on dpfa_pkg.
module dpfa_ptab (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [dpfa_pkg::VP_W-1:0] rd_addr,
  output dpfa_pkg::pt_entry_t      rd_data,
  input  dpfa_pkg::pt_wr_t         wr,
  output logic                     ready
);
  import dpfa_pkg::*;

  pt_entry_t       mem [VP_DEPTH];
  pt_entry_t       rd_data_r;
  logic [VP_W-1:0] clr_idx_r;
  logic            ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      ready_r   <= 1'b0;
    end else if (!ready_r) begin
      clr_idx_r <= clr_idx_r + VP_W'(1);
      if (clr_idx_r == VP_W'(VP_DEPTH - 1)) begin
        ready_r <= 1'b1;
      end
    end
  end

  // The clearing pass owns the write port until it has swept every entry.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (!ready_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = ready_r;

endmodule

[sim/demand_page_frame_allocator_tb.sv]
// Self-checking testbench for the demand page frame allocator: drives map and
// evict items, predicts each result with a behavioral model and checks them in order.
// Depends on dpfa_pkg and demand_page_frame_allocator.
module demand_page_frame_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dpfa_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_PAUSE  = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOT_N        = 24;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  in_item_t          in_item   = '0;
  logic              out_strobe;
  out_item_t         out_item;
  logic              cfg_we    = 1'b0;
  logic [MAXP_W-1:0] cfg_wdata = '0;

  demand_page_frame_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Allocator state as the testbench sees it.
  bit            pt_valid   [VP_DEPTH];
  bit [PP_W-1:0] pt_frame   [VP_DEPTH];
  bit [PP_W-1:0] keep_stack [PP_DEPTH];
  bit [PP_W-1:0] drop_stack [PP_DEPTH];
  bit [VP_W-1:0] evict_fifo [EQ_DEPTH];
  int            keep_depth;
  int            drop_depth;
  int            evict_depth;
  int            fresh_frames;
  int            frame_cap;

  in_item_t      page_requests[$];
  out_item_t     predicted_results[$];
  out_item_t     want;
  bit [VP_W-1:0] hot_pages [HOT_N];
  int            send_idle_pct = 17;
  bit            all_settled   = 1'b0;
  int            planned_items = 0;
  int            items_offered = 0;
  int            items_sent    = 0;
  int            results_seen  = 0;
  int            mismatches    = 0;
  int            cycle_count   = 0;
  int            kind_seen [8];

  function automatic void expect_result(kind_t k, logic [VP_W-1:0] vp, logic [PP_W-1:0] pp,
                                        logic last);
    out_item_t r;
    r.kind          = k;
    r.virtual_page  = vp;
    r.physical_page = pp;
    r.last          = last;
    predicted_results = {predicted_results, r};
  endfunction

  function automatic void predict_allocation(in_item_t it);
    logic [VP_W-1:0] pg;
    logic [VP_W-1:0] vp;
    logic [PP_W-1:0] fr;
    int              cap;
    int              i;
    bit              mapped;
    pg     = it.page_id;
    mapped = 1'b0;
    fr     = '0;
    if (it.op == OP_EVICT) begin
      if (evict_depth < EQ_DEPTH) begin
        evict_fifo[evict_depth] = pg;
        evict_depth++;
        expect_result(K_QUEUED, pg, '0, 1'b1);
      end else begin
        expect_result(K_QUEUE_FULL, pg, '0, 1'b1);
      end
      return;
    end
    // Drain in queue order. Frames keep their backing while the reuse stack
    // is smaller than half the queued count.
    for (i = 0; i < evict_depth; i++) begin
      vp = evict_fifo[i];
      if (pt_valid[vp]) begin
        fr           = pt_frame[vp];
        pt_valid[vp] = 1'b0;
        if (keep_depth < evict_depth / 2 && keep_depth < PP_DEPTH) begin
          keep_stack[keep_depth] = fr;
          keep_depth++;
          expect_result(K_EVICT_KEPT, vp, fr, 1'b0);
        end else begin
          if (drop_depth < PP_DEPTH) begin
            drop_stack[drop_depth] = fr;
            drop_depth++;
          end
          expect_result(K_EVICT_RELEASED, vp, fr, 1'b0);
        end
      end
    end
    evict_depth = 0;
    cap = (frame_cap > PP_DEPTH) ? PP_DEPTH : frame_cap;
    if (pt_valid[pg]) begin
      expect_result(K_ALREADY, pg, pt_frame[pg], 1'b1);
    end else if (keep_depth > 0) begin
      keep_depth--;
      fr     = keep_stack[keep_depth];
      mapped = 1'b1;
      expect_result(K_MAP_REUSE, pg, fr, 1'b1);
    end else if (drop_depth > 0) begin
      drop_depth--;
      fr     = drop_stack[drop_depth];
      mapped = 1'b1;
      expect_result(K_MAP_NEW, pg, fr, 1'b1);
    end else if (fresh_frames < cap) begin
      fr = fresh_frames[PP_W-1:0];
      fresh_frames++;
      mapped = 1'b1;
      expect_result(K_MAP_NEW, pg, fr, 1'b1);
    end else begin
      expect_result(K_EXHAUSTED, pg, '0, 1'b1);
    end
    if (mapped) begin
      pt_valid[pg] = 1'b1;
      pt_frame[pg] = fr;
    end
  endfunction

  function automatic void add_item(op_t op, logic [VP_W-1:0] pg);
    in_item_t it;
    it.op      = op;
    it.page_id = pg;
    page_requests = {page_requests, it};
    planned_items++;
  endfunction

  // Mostly a small set of pages, so that evicts hit mapped pages and pages repeat.
  function automatic logic [VP_W-1:0] pick_page();
    if ($urandom_range(0, 99) < 85) return hot_pages[$urandom_range(0, HOT_N - 1)];
    return VP_W'($urandom_range(0, VP_DEPTH - 1));
  endfunction

  function automatic void plan_traffic(int n);
    int target;
    int sel;
    int cnt;
    target = planned_items + n;
    while (planned_items < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // Fill the queue to near or past its depth before the next map.
        cnt = $urandom_range(EQ_DEPTH - 2, EQ_DEPTH + 3);
        repeat (cnt) add_item(OP_EVICT, pick_page());
        add_item(OP_MAP, pick_page());
      end else if (sel < 55) begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) add_item(OP_EVICT, pick_page());
        cnt = $urandom_range(1, 3);
        repeat (cnt) add_item(OP_MAP, pick_page());
      end else if (sel < 80) begin
        cnt = $urandom_range(2, 6);
        repeat (cnt) add_item(OP_MAP, pick_page());
      end else begin
        add_item($urandom_range(0, 1) ? OP_EVICT : OP_MAP,
                 VP_W'($urandom_range(0, VP_DEPTH - 1)));
      end
    end
  endfunction

  task automatic write_limit(logic [MAXP_W-1:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (!all_settled);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  // Driver: a new item is offered only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || items_sent == items_offered) begin
      if (page_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item <= page_requests.pop_front();
        start   <= 1'b1;
        items_offered++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks results, tracks register writes and predicts accepted items.
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pt_valid[j]) pt_valid[j] = 1'b0;
      keep_depth   = 0;
      drop_depth   = 0;
      evict_depth  = 0;
      fresh_frames = 0;
      frame_cap    = PP_DEPTH;
    end else begin
      if (out_strobe) begin
        results_seen++;
        kind_seen[out_item.kind]++;
        if (predicted_results.size() == 0) begin
          $display("%0t ns: unexpected result kind %0d vp %0d pp %0d last %0d", $time,
                   out_item.kind, out_item.virtual_page, out_item.physical_page, out_item.last);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_item.kind !== want.kind || out_item.virtual_page !== want.virtual_page ||
              out_item.physical_page !== want.physical_page || out_item.last !== want.last) begin
            $display("%0t ns: expected kind %0d vp %0d pp %0d last %0d,",
                     $time, want.kind, want.virtual_page, want.physical_page, want.last,
                     " got kind %0d vp %0d pp %0d last %0d",
                     out_item.kind, out_item.virtual_page, out_item.physical_page, out_item.last);
            mismatches++;
          end
        end
      end
      if (cfg_we) frame_cap = int'(cfg_wdata);
      if (start && !busy) begin
        predict_allocation(in_item);
        items_sent++;
      end
    end
    all_settled = page_requests.size() == 0 && !start && predicted_results.size() == 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               predicted_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int k = 2; k < HOT_N; k++) hot_pages[k] = VP_W'($urandom_range(0, VP_DEPTH - 1));
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with room for three fresh frames: fresh, already mapped,
    // exhausted, duplicate and unmapped queue entries, kept and released frames.
    write_limit(9'd3);
    add_item(OP_MAP, 10'd0);
    add_item(OP_MAP, 10'd1023);
    add_item(OP_MAP, 10'd0);
    add_item(OP_MAP, 10'd5);
    add_item(OP_MAP, 10'd6);
    add_item(OP_EVICT, 10'd0);
    add_item(OP_EVICT, 10'd1023);
    add_item(OP_EVICT, 10'd0);
    add_item(OP_EVICT, 10'd7);
    add_item(OP_EVICT, 10'd5);
    add_item(OP_MAP, 10'd6);
    add_item(OP_MAP, 10'd9);
    add_item(OP_MAP, 10'd10);
    add_item(OP_MAP, 10'd11);
    add_item(OP_EVICT, 10'd682);
    add_item(OP_EVICT, 10'd341);
    add_item(OP_MAP, 10'd682);
    add_item(OP_EVICT, 10'd6);
    add_item(OP_MAP, 10'd341);
    wait_drained();

    write_limit(9'd256);
    plan_traffic(70);
    wait_drained();

    send_idle_pct = 65;
    write_limit(9'd0);
    plan_traffic(40);
    wait_drained();

    write_limit(9'd1);
    plan_traffic(40);
    wait_drained();

    // A limit above the frame count saturates.
    send_idle_pct = 0;
    write_limit(9'd511);
    plan_traffic(60);
    wait_drained();

    if (predicted_results.size() != 0) begin
      $display("%0d expected results never arrived", predicted_results.size());
      mismatches++;
    end
    $display("Sent %0d items and checked %0d results under frame limits 3, 256, 0, 1 and 511,",
             items_sent, results_seen);
    $display("kinds 0..7 seen %0d %0d %0d %0d %0d %0d %0d %0d times, %0d mismatches.",
             kind_seen[K_EVICT_KEPT], kind_seen[K_EVICT_RELEASED], kind_seen[K_MAP_REUSE],
             kind_seen[K_MAP_NEW], kind_seen[K_ALREADY], kind_seen[K_EXHAUSTED],
             kind_seen[K_QUEUED], kind_seen[K_QUEUE_FULL], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
